// ===== rtl/iffcs_pkg.sv =====
// Package for the container chunk scanner: field widths, scan phases,
// the known chunk tags and the tag lookup function.
// No dependencies; used by iff_chunk_scanner_unit.
package iffcs_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LENGTH_W = 24;
  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned SHIFT_W  = 32;
  localparam int unsigned COUNT_W  = 4;

  // Default width of the byte position counter
  localparam int unsigned POSITION_BITS_DEF = 24;

  // Header lengths in bytes
  localparam logic [COUNT_W-1:0] FORM_HEADER_BYTES  = COUNT_W'(12);
  localparam logic [COUNT_W-1:0] CHUNK_HEADER_BYTES = COUNT_W'(8);
  localparam logic [COUNT_W-1:0] TAG_BYTES          = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] TAG_LAST_BYTE      = COUNT_W'(3);

  // Scan phase; the unused code behaves like the form header phase
  typedef enum logic [1:0] {
    PH_FORM   = 2'd0,
    PH_HEADER = 2'd1,
    PH_SKIP   = 2'd2
  } phase_t;

  // Chunk kinds reported on the result channel
  typedef enum logic [KIND_W-1:0] {
    KIND_ATU8 = 2'd0,
    KIND_CODE = 2'd1,
    KIND_LOCT = 2'd2,
    KIND_IMPT = 2'd3
  } kind_t;

  // Known tags, big-endian ASCII
  localparam logic [SHIFT_W-1:0] TAG_ATU8 = 32'h4174_5538;
  localparam logic [SHIFT_W-1:0] TAG_CODE = 32'h436F_6465;
  localparam logic [SHIFT_W-1:0] TAG_LOCT = 32'h4C6F_6354;
  localparam logic [SHIFT_W-1:0] TAG_IMPT = 32'h496D_7054;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } tag_match_t;

  // Compare a full tag against the four known ones
  function automatic tag_match_t match_tag(input logic [SHIFT_W-1:0] tag);
    tag_match_t m;
    m.hit  = 1'b1;
    m.kind = KIND_ATU8;
    if (tag == TAG_ATU8) begin
      m.kind = KIND_ATU8;
    end else if (tag == TAG_CODE) begin
      m.kind = KIND_CODE;
    end else if (tag == TAG_LOCT) begin
      m.kind = KIND_LOCT;
    end else if (tag == TAG_IMPT) begin
      m.kind = KIND_IMPT;
    end else begin
      m.hit = 1'b0;
    end
    return m;
  endfunction

  // Round a chunk size up to a multiple of 4, saturating at all ones
  function automatic logic [SHIFT_W-1:0] round_skip(input logic [SHIFT_W-1:0] size);
    logic [SHIFT_W:0] r;
    r = ({1'b0, size} + (SHIFT_W+1)'(3)) & ~((SHIFT_W+1)'(3));
    return r[SHIFT_W] ? {SHIFT_W{1'b1}} : r[SHIFT_W-1:0];
  endfunction

endpackage

// ===== rtl/iff_chunk_scanner_unit.sv =====
// Chunk scanner for IFF-style container files, top level.
// Depends on iffcs_pkg for widths, phases, tags and the tag lookup.
//
// Takes one file byte per word and reports every AtU8, Code, LocT or ImpT
// chunk with its kind and the position of its header. The scan state advances
// on the clock edge that accepts the byte, and a match is written into a
// single result register on that same edge, so a result is offered the cycle
// after its fourth tag byte. A byte can be accepted in every cycle; in_stall
// is raised only while the result register holds a word and out_stall holds it
// there. The form header is skipped unchecked, bodies are skipped with padding
// to 4 bytes, bytes at or past file_length are dropped, and in_start_of_file
// restarts the scan at zero. The user must write file_length through the cfg
// port while no bytes are in flight; the block does not enforce it.
module iff_chunk_scanner_unit #(
  parameter int unsigned POSITION_BITS = iffcs_pkg::POSITION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // byte stream
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [iffcs_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic                            in_start_of_file,
  // chunk reports
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [iffcs_pkg::KIND_W-1:0]    out_chunk_kind,
  output logic [iffcs_pkg::OFFSET_W-1:0]  out_chunk_offset,
  // file length register
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [iffcs_pkg::LENGTH_W-1:0]  cfg_file_length
);

  localparam int unsigned SW    = iffcs_pkg::SHIFT_W;
  localparam int unsigned CW    = iffcs_pkg::COUNT_W;
  localparam int unsigned CMP_W = (POSITION_BITS > iffcs_pkg::LENGTH_W) ?
                                  POSITION_BITS : iffcs_pkg::LENGTH_W;

  // Registers
  logic [iffcs_pkg::LENGTH_W-1:0] file_length_r;
  logic [POSITION_BITS-1:0]       pos_r, pos_nxt;
  iffcs_pkg::phase_t              phase_r, phase_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic [SW-1:0]                  tag_r, tag_nxt;
  logic [SW-1:0]                  size_r, size_nxt;
  logic [SW-1:0]                  skip_r, skip_nxt;
  logic [iffcs_pkg::OFFSET_W-1:0] cstart_r, cstart_nxt;
  logic                           out_valid_r, out_valid_nxt;
  iffcs_pkg::kind_t               out_kind_r, out_kind_nxt;
  logic [iffcs_pkg::OFFSET_W-1:0] out_off_r, out_off_nxt;

  // Combinational helpers
  logic                           accept;
  logic                           active;
  logic                           hit;
  iffcs_pkg::kind_t               hit_kind;
  logic [POSITION_BITS-1:0]       pos_eff;
  iffcs_pkg::phase_t              phase_eff;
  logic [CW-1:0]                  cnt_eff, cnt_inc;
  logic [SW-1:0]                  tag_eff, size_eff, skip_eff, skip_dec, tag_cat;
  logic [iffcs_pkg::OFFSET_W-1:0] cstart_eff;
  logic [CMP_W-1:0]               pos_cmp;
  iffcs_pkg::tag_match_t          tm;

  // Handshakes: stall only while a held result cannot move on
  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;

  assign out_valid        = out_valid_r;
  assign out_chunk_kind   = out_kind_r;
  assign out_chunk_offset = out_off_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      file_length_r <= cfg_file_length;
    end
  end

  // Scan state update for one byte
  always_comb begin
    // start of file clears the scan before the byte is handled
    pos_eff    = in_start_of_file ? '0 : pos_r;
    phase_eff  = in_start_of_file ? iffcs_pkg::PH_FORM : phase_r;
    cnt_eff    = in_start_of_file ? '0 : cnt_r;
    tag_eff    = in_start_of_file ? '0 : tag_r;
    size_eff   = in_start_of_file ? '0 : size_r;
    skip_eff   = in_start_of_file ? '0 : skip_r;
    cstart_eff = in_start_of_file ? '0 : cstart_r;

    pos_cmp  = CMP_W'(pos_eff);
    active   = pos_cmp < CMP_W'(file_length_r);
    cnt_inc  = cnt_eff + CW'(1);
    tag_cat  = {tag_eff[SW-9:0], in_data_byte};
    tm       = iffcs_pkg::match_tag(tag_cat);
    skip_dec = (skip_eff != '0) ? skip_eff - SW'(1) : skip_eff;
    hit      = 1'b0;
    hit_kind = tm.kind;

    pos_nxt    = pos_eff;
    phase_nxt  = phase_eff;
    cnt_nxt    = cnt_eff;
    tag_nxt    = tag_eff;
    size_nxt   = size_eff;
    skip_nxt   = skip_eff;
    cstart_nxt = cstart_eff;

    if (active) begin
      pos_nxt = pos_eff + POSITION_BITS'(1);
      case (phase_eff)
        iffcs_pkg::PH_HEADER: begin
          if (cnt_eff == '0) begin
            cstart_nxt = pos_cmp[iffcs_pkg::OFFSET_W-1:0];
          end
          if (cnt_eff < iffcs_pkg::TAG_BYTES) begin
            tag_nxt = tag_cat;
            if (cnt_eff == iffcs_pkg::TAG_LAST_BYTE) begin
              hit = tm.hit;
            end
          end else begin
            size_nxt = {size_eff[SW-9:0], in_data_byte};
          end
          cnt_nxt = cnt_inc;
          if (cnt_inc >= iffcs_pkg::CHUNK_HEADER_BYTES) begin
            cnt_nxt   = '0;
            skip_nxt  = iffcs_pkg::round_skip(size_nxt);
            phase_nxt = (skip_nxt == '0) ? iffcs_pkg::PH_HEADER : iffcs_pkg::PH_SKIP;
          end
        end
        iffcs_pkg::PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            phase_nxt = iffcs_pkg::PH_HEADER;
            cnt_nxt   = '0;
          end
        end
        default: begin
          // form header, and the unused phase code
          cnt_nxt = cnt_inc;
          if (cnt_inc >= iffcs_pkg::FORM_HEADER_BYTES) begin
            cnt_nxt   = '0;
            phase_nxt = iffcs_pkg::PH_HEADER;
          end
        end
      endcase
    end
  end

  // Scan state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      phase_r  <= iffcs_pkg::PH_FORM;
      cnt_r    <= '0;
      tag_r    <= '0;
      size_r   <= '0;
      skip_r   <= '0;
      cstart_r <= '0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      tag_r    <= tag_nxt;
      size_r   <= size_nxt;
      skip_r   <= skip_nxt;
      cstart_r <= cstart_nxt;
    end
  end

  // Result register: load on a match, drain when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_off_nxt   = out_off_r;
    if (accept && hit) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = hit_kind;
      out_off_nxt   = cstart_eff;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_kind_r <= out_kind_nxt;
    out_off_r  <= out_off_nxt;
  end

  // Checks on the scan state
  a_form_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == iffcs_pkg::PH_FORM) |-> (cnt_r < iffcs_pkg::FORM_HEADER_BYTES))
    else $error("form header count out of range");

  a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == iffcs_pkg::PH_HEADER) |-> (cnt_r < iffcs_pkg::CHUNK_HEADER_BYTES))
    else $error("chunk header count out of range");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == iffcs_pkg::PH_SKIP) |-> (skip_r != '0))
    else $error("skip phase with nothing left to skip");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |->
      $past(in_valid && !in_stall))
    else $error("result word without an accepted byte");

endmodule

// ===== tb/sv/iffcs_chunk_checker.sv =====
`timescale 1ns / 1ps
// Chunk report checker for iff_chunk_scanner_unit: follows the scan from the
// accepted byte words and compares each chunk report word with its prediction.
// Depends on iffcs_pkg for phases, kinds, tags, widths and header lengths.
module iffcs_chunk_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [iffcs_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                           in_start_of_file,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [iffcs_pkg::KIND_W-1:0]   out_chunk_kind,
  input  logic [iffcs_pkg::OFFSET_W-1:0] out_chunk_offset,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [iffcs_pkg::LENGTH_W-1:0] cfg_file_length,
  output int                             reports_due,
  output int                             mismatches
);

  localparam int unsigned CW = iffcs_pkg::COUNT_W;
  localparam int unsigned SW = iffcs_pkg::SHIFT_W;
  localparam int unsigned PW = iffcs_pkg::POSITION_BITS_DEF;

  typedef struct packed {
    iffcs_pkg::kind_t               kind;
    logic [iffcs_pkg::OFFSET_W-1:0] offset;
  } chunk_report_t;

  chunk_report_t due_q[$];
  int            due_cnt = 0;
  int            errs = 0;

  // Shadow copy of the scan state and the file length register
  logic [iffcs_pkg::LENGTH_W-1:0] file_len;
  logic [PW-1:0]                  byte_pos;
  iffcs_pkg::phase_t              phase;
  logic [CW-1:0]                  hdr_cnt;
  logic [SW-1:0]                  tag_sr;
  logic [SW-1:0]                  size_sr;
  logic [SW-1:0]                  skip_left;
  logic [iffcs_pkg::OFFSET_W-1:0] hdr_pos;

  assign reports_due = due_cnt;
  assign mismatches  = errs;

  function automatic void restart_scan();
    byte_pos  = '0;
    phase     = iffcs_pkg::PH_FORM;
    hdr_cnt   = '0;
    tag_sr    = '0;
    size_sr   = '0;
    skip_left = '0;
    hdr_pos   = '0;
  endfunction

  // Advance the scan by one byte; queue a report when a known tag completes
  task automatic scan_byte(input logic [iffcs_pkg::BYTE_W-1:0] b, input logic sof);
    logic [SW:0]   padded;
    chunk_report_t rep;
    logic          hit;
    if (sof) restart_scan();
    // bytes at or past the file length leave the state alone
    if (byte_pos >= file_len) return;
    case (phase)
      iffcs_pkg::PH_HEADER: begin
        if (hdr_cnt == '0) hdr_pos = byte_pos[iffcs_pkg::OFFSET_W-1:0];
        if (hdr_cnt < iffcs_pkg::TAG_BYTES) begin
          tag_sr = {tag_sr[SW-9:0], b};
          if (hdr_cnt == iffcs_pkg::TAG_LAST_BYTE) begin
            hit = 1'b1;
            rep.offset = hdr_pos;
            case (tag_sr)
              iffcs_pkg::TAG_ATU8: rep.kind = iffcs_pkg::KIND_ATU8;
              iffcs_pkg::TAG_CODE: rep.kind = iffcs_pkg::KIND_CODE;
              iffcs_pkg::TAG_LOCT: rep.kind = iffcs_pkg::KIND_LOCT;
              iffcs_pkg::TAG_IMPT: rep.kind = iffcs_pkg::KIND_IMPT;
              default: begin
                rep.kind = iffcs_pkg::KIND_ATU8;
                hit = 1'b0;
              end
            endcase
            if (hit) due_q.push_back(rep);
          end
        end else begin
          size_sr = {size_sr[SW-9:0], b};
        end
        hdr_cnt = hdr_cnt + CW'(1);
        if (hdr_cnt >= iffcs_pkg::CHUNK_HEADER_BYTES) begin
          hdr_cnt = '0;
          // body plus padding to 4 bytes, saturating when it overflows
          padded = ({1'b0, size_sr} + (SW+1)'(3)) & ~((SW+1)'(3));
          skip_left = padded[SW] ? {SW{1'b1}} : padded[SW-1:0];
          phase = (skip_left == '0) ? iffcs_pkg::PH_HEADER : iffcs_pkg::PH_SKIP;
        end
      end
      iffcs_pkg::PH_SKIP: begin
        if (skip_left != '0) skip_left = skip_left - SW'(1);
        if (skip_left == '0) begin
          phase   = iffcs_pkg::PH_HEADER;
          hdr_cnt = '0;
        end
      end
      default: begin
        // form header, unchecked
        hdr_cnt = hdr_cnt + CW'(1);
        if (hdr_cnt >= iffcs_pkg::FORM_HEADER_BYTES) begin
          hdr_cnt = '0;
          phase   = iffcs_pkg::PH_HEADER;
        end
      end
    endcase
    byte_pos = byte_pos + PW'(1);
  endtask

  // Watch all three channels at each edge
  always @(posedge clk) begin : watch
    chunk_report_t want;
    if (!rst_n) begin
      file_len = '0;
      restart_scan();
      due_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $error("unexpected report word: chunk_kind %0d chunk_offset %0d",
                 out_chunk_kind, out_chunk_offset);
          errs++;
        end else begin
          want = due_q.pop_front();
          if (out_chunk_kind !== want.kind) begin
            $error("chunk_kind: expected %0d, got %0d", want.kind, out_chunk_kind);
            errs++;
          end
          if (out_chunk_offset !== want.offset) begin
            $error("chunk_offset: expected %0d, got %0d", want.offset, out_chunk_offset);
            errs++;
          end
        end
      end
      if (cfg_valid && cfg_ready) file_len = cfg_file_length;
      if (in_valid && !in_stall) scan_byte(in_data_byte, in_start_of_file);
    end
    due_cnt <= due_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Top of the chunk scanner testbench: clock, reset, byte stream stimulus,
// file length writes and the verdict. Needs iffcs_pkg, iff_chunk_scanner_unit
// and iffcs_chunk_checker.
module tb;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int N_PHASES     = 9;
  localparam int unsigned LW  = iffcs_pkg::LENGTH_W;
  localparam logic [iffcs_pkg::SHIFT_W-1:0] KNOWN_TAGS [4] = '{
    iffcs_pkg::TAG_ATU8, iffcs_pkg::TAG_CODE, iffcs_pkg::TAG_LOCT, iffcs_pkg::TAG_IMPT
  };

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic [iffcs_pkg::BYTE_W-1:0]   in_data_byte = '0;
  logic                           in_start_of_file = 1'b0;
  logic                           out_stall = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic [LW-1:0]                  cfg_file_length = '0;
  logic                           in_stall;
  logic                           out_valid;
  logic [iffcs_pkg::KIND_W-1:0]   out_chunk_kind;
  logic [iffcs_pkg::OFFSET_W-1:0] out_chunk_offset;
  logic                           cfg_ready;

  int          idle_pct = 37;
  int          quiet = 0;
  int          reports_due;
  int          mismatches;
  logic [7:0]  file_q[$];

  always #5 clk = ~clk;

  iff_chunk_scanner_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_start_of_file (in_start_of_file),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chunk_kind   (out_chunk_kind),
    .out_chunk_offset (out_chunk_offset),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_file_length  (cfg_file_length)
  );

  iffcs_chunk_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_start_of_file (in_start_of_file),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chunk_kind   (out_chunk_kind),
    .out_chunk_offset (out_chunk_offset),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_file_length  (cfg_file_length),
    .reports_due      (reports_due),
    .mismatches       (mismatches)
  );

  // Random back-pressure on the report channel
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  // Watchdog: too long without any word moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QUIET_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // One byte word, after a random idle gap
  task automatic send_byte(input logic [7:0] b, input logic sof);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_start_of_file <= sof;
    do @(posedge clk); while (in_stall);
  endtask

  // Stream file_q; stray restarts mid-file when asked
  task automatic send_file(input bit stray_restarts);
    for (int i = 0; i < file_q.size(); i++) begin
      send_byte(file_q[i], (i == 0) || (stray_restarts && $urandom_range(199) == 0));
    end
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) file_q.push_back(w[8*i +: 8]);
  endtask

  // Mostly well-formed files with random content, some noise and truncation
  task automatic build_file();
    int          n_chunks;
    int          pick;
    int          body_len;
    int          cut;
    logic [31:0] tag;
    logic [31:0] size;
    file_q.delete();
    repeat (12) file_q.push_back(8'($urandom_range(255)));
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(40)) file_q.push_back(8'($urandom_range(255)));
      return;
    end
    n_chunks = $urandom_range(1, 5);
    for (int c = 0; c < n_chunks; c++) begin
      tag  = KNOWN_TAGS[$urandom_range(3)];
      pick = $urandom_range(99);
      if (pick >= 85) tag = $urandom;
      else if (pick >= 72) tag = tag ^ (32'h1 << $urandom_range(31));
      pick = $urandom_range(99);
      if (pick < 4) size = $urandom;
      else if (pick < 6) size = 32'hFFFF_FFFC + $urandom_range(3);
      else if (pick < 20) size = '0;
      else size = $urandom_range(1, 13);
      push_word(tag);
      push_word(size);
      if (size > 64) begin
        // huge body: the rest of the file lies inside it
        repeat ($urandom_range(20)) file_q.push_back(8'($urandom_range(255)));
        return;
      end
      body_len = (int'(size) + 3) & ~3;
      repeat (body_len) file_q.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(99) < 10) begin
      cut = $urandom_range(file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
  endtask

  // Write the length register once the scanner has gone quiet
  task automatic set_file_length(input logic [LW-1:0] len);
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_file_length <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int            budget;
    int            sent;
    logic [LW-1:0] len;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: len = '1;
        1: len = '0;
        2: len = LW'($urandom_range(12, 60));
        3: len = '1;
        default: begin
          case ($urandom_range(3))
            0, 1: len = '1;
            2: len = LW'($urandom_range(1, 120));
            default: len = LW'($urandom);
          endcase
        end
      endcase
      // one phase runs without any idling on either side
      idle_pct = (ph == 3) ? 0 : 37;
      set_file_length(len);
      if (ph == 0) begin
        // extremes in the form header, an empty AtU8, then an ImpT of huge size
        file_q.delete();
        for (int i = 0; i < 12; i++) file_q.push_back((i % 2) ? 8'hFF : 8'h00);
        push_word(iffcs_pkg::TAG_ATU8);
        push_word(32'h0000_0000);
        push_word(iffcs_pkg::TAG_IMPT);
        push_word(32'hFFFF_FFFF);
        file_q.push_back(8'h00);
        file_q.push_back(8'hFF);
        send_file(1'b0);
      end
      budget = (ph == 1) ? 50 : 175;
      sent   = 0;
      while (sent < budget) begin
        build_file();
        send_file(1'b1);
        sent += file_q.size();
      end
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
